@@ design/uart_dual_ring_buffer_core_defines.svh @@
// Assertion macros used by the checker file of the dual ring buffer core.
`ifndef UART_DUAL_RING_BUFFER_CORE_DEFINES_SVH
`define UART_DUAL_RING_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UDRB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("udrb assertion failed");

// Next-cycle implication, disabled during reset.
`define UDRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("udrb assertion failed");

`endif

@@ design/udrb_pkg.sv @@
// Package: depths, widths, event codes and shared structs of the dual ring buffer.
`timescale 1ns / 1ps
package udrb_pkg;

    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 4096;

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    localparam logic [2:0] KIND_SEND     = 3'd0;
    localparam logic [2:0] KIND_READ     = 3'd1;
    localparam logic [2:0] KIND_LINE_RX  = 3'd2;
    localparam logic [2:0] KIND_TX_READY = 3'd3;
    localparam logic [2:0] KIND_FLUSH_TX = 3'd4;
    localparam logic [2:0] KIND_FLUSH_RX = 3'd5;

    typedef struct packed {
        logic             we;
        logic [TX_AW-1:0] waddr;
        logic             re;
        logic [TX_AW-1:0] raddr;
    } tx_req_t;

    typedef struct packed {
        logic             we;
        logic [RX_AW-1:0] waddr;
        logic             re;
        logic [RX_AW-1:0] raddr;
    } rx_req_t;

    typedef struct packed {
        logic read_valid;
        logic line_valid;
        logic send_refused;
        logic rx_dropped;
        logic tx_irq_enable;
        logic tx_space;
        logic tx_empty;
        logic rx_empty;
    } flags_t;

endpackage

@@ design/udrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module udrb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/udrb_ctrl.sv @@
// Ring bookkeeping: indices, counts, interrupt enable, RAM strobes and result flags.
`timescale 1ns / 1ps
module udrb_ctrl import udrb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       en,
    input  logic [2:0] kind,
    input  logic       line_ready,
    output tx_req_t    tx_req,
    output rx_req_t    rx_req,
    output flags_t     flags
);

    logic [TX_AW-1:0] tx_wr_idx_reg, tx_wr_idx_next;
    logic [TX_AW-1:0] tx_rd_idx_reg, tx_rd_idx_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic [RX_AW-1:0] rx_wr_idx_reg, rx_wr_idx_next;
    logic [RX_AW-1:0] rx_rd_idx_reg, rx_rd_idx_next;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic             tx_irq_reg, tx_irq_next;

    logic tx_full, rx_full;

    assign tx_full = (tx_count_reg == TX_CW'(TX_DEPTH));
    assign rx_full = (rx_count_reg == RX_CW'(RX_DEPTH));

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] i);
        return (i == TX_AW'(TX_DEPTH - 1)) ? '0 : i + TX_AW'(1);
    endfunction

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] i);
        return (i == RX_AW'(RX_DEPTH - 1)) ? '0 : i + RX_AW'(1);
    endfunction

    always_comb begin
        tx_wr_idx_next = tx_wr_idx_reg;
        tx_rd_idx_next = tx_rd_idx_reg;
        tx_count_next  = tx_count_reg;
        rx_wr_idx_next = rx_wr_idx_reg;
        rx_rd_idx_next = rx_rd_idx_reg;
        rx_count_next  = rx_count_reg;
        tx_irq_next    = tx_irq_reg;

        tx_req.we    = 1'b0;
        tx_req.waddr = tx_wr_idx_reg;
        tx_req.re    = 1'b0;
        tx_req.raddr = tx_rd_idx_reg;
        rx_req.we    = 1'b0;
        rx_req.waddr = rx_wr_idx_reg;
        rx_req.re    = 1'b0;
        rx_req.raddr = rx_rd_idx_reg;

        flags = '0;

        if (advance && en) begin
            case (kind)
                KIND_SEND: begin
                    if (!tx_full) begin
                        tx_req.we      = 1'b1;
                        tx_wr_idx_next = tx_inc(tx_wr_idx_reg);
                        tx_count_next  = tx_count_reg + TX_CW'(1);
                        tx_irq_next    = 1'b1;
                    end else begin
                        flags.send_refused = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (rx_count_reg != '0) begin
                        rx_req.re        = 1'b1;
                        flags.read_valid = 1'b1;
                        rx_rd_idx_next   = rx_inc(rx_rd_idx_reg);
                        rx_count_next    = rx_count_reg - RX_CW'(1);
                    end
                end
                KIND_LINE_RX: begin
                    if (!rx_full) begin
                        rx_req.we      = 1'b1;
                        rx_wr_idx_next = rx_inc(rx_wr_idx_reg);
                        rx_count_next  = rx_count_reg + RX_CW'(1);
                    end else begin
                        flags.rx_dropped = 1'b1;
                    end
                end
                KIND_TX_READY: begin
                    if (tx_count_reg == '0) begin
                        tx_irq_next = 1'b0;
                    end else if (line_ready) begin
                        tx_req.re        = 1'b1;
                        flags.line_valid = 1'b1;
                        tx_rd_idx_next   = tx_inc(tx_rd_idx_reg);
                        tx_count_next    = tx_count_reg - TX_CW'(1);
                    end
                end
                KIND_FLUSH_TX: begin
                    tx_wr_idx_next = '0;
                    tx_rd_idx_next = '0;
                    tx_count_next  = '0;
                end
                KIND_FLUSH_RX: begin
                    rx_wr_idx_next = '0;
                    rx_rd_idx_next = '0;
                    rx_count_next  = '0;
                end
                default: begin
                end
            endcase
        end

        flags.tx_irq_enable = tx_irq_next;
        flags.tx_space      = !en || (tx_count_next != TX_CW'(TX_DEPTH));
        flags.tx_empty      = !en || (tx_count_next == '0);
        flags.rx_empty      = !en || (rx_count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_wr_idx_reg <= '0;
            tx_rd_idx_reg <= '0;
            tx_count_reg  <= '0;
            rx_wr_idx_reg <= '0;
            rx_rd_idx_reg <= '0;
            rx_count_reg  <= '0;
            tx_irq_reg    <= 1'b0;
        end else begin
            tx_wr_idx_reg <= tx_wr_idx_next;
            tx_rd_idx_reg <= tx_rd_idx_next;
            tx_count_reg  <= tx_count_next;
            rx_wr_idx_reg <= rx_wr_idx_next;
            rx_rd_idx_reg <= rx_rd_idx_next;
            rx_count_reg  <= rx_count_next;
            tx_irq_reg    <= tx_irq_next;
        end
    end

endmodule

@@ design/uart_dual_ring_buffer_core.sv @@
// Top level of the dual ring buffer core: pipeline registers, rings and config register.
// One transaction is accepted per cycle while the result side is not stalled; it passes
// through the input register, then the ring update and the synchronous RAM read land
// together in the result register. The receive ring is a 4096-byte RAM and the transmit
// ring a 16-byte RAM, each with one write and one registered read port; no clearing
// pass is needed after reset. Backpressure on the result side stalls the input register.
`timescale 1ns / 1ps
module uart_dual_ring_buffer_core import udrb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_kind,
    input  logic [7:0] s_data_byte,
    input  logic       s_line_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic       m_read_valid,
    output logic [7:0] m_line_byte,
    output logic       m_line_valid,
    output logic       m_send_refused,
    output logic       m_rx_dropped,
    output logic       m_tx_irq_enable,
    output logic       m_tx_space,
    output logic       m_tx_empty,
    output logic       m_rx_empty
);

    logic       enabled_reg;
    logic       in_valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] data_reg;
    logic       line_ready_reg;
    logic       out_valid_reg;
    flags_t     flags_reg;
    flags_t     flags;
    tx_req_t    tx_req;
    rx_req_t    rx_req;
    logic [7:0] tx_q;
    logic [7:0] rx_q;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enabled_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg       <= s_kind;
            data_reg       <= s_data_byte;
            line_ready_reg <= s_line_ready;
        end
        if (advance) begin
            flags_reg <= flags;
        end
    end

    udrb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .en         (enabled_reg),
        .kind       (kind_reg),
        .line_ready (line_ready_reg),
        .tx_req     (tx_req),
        .rx_req     (rx_req),
        .flags      (flags)
    );

    udrb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_req.we),
        .wr_addr (tx_req.waddr),
        .wr_data (data_reg),
        .rd_en   (tx_req.re),
        .rd_addr (tx_req.raddr),
        .rd_data (tx_q)
    );

    udrb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_req.we),
        .wr_addr (rx_req.waddr),
        .wr_data (data_reg),
        .rd_en   (rx_req.re),
        .rd_addr (rx_req.raddr),
        .rd_data (rx_q)
    );

    assign m_valid         = out_valid_reg;
    assign m_read_valid    = flags_reg.read_valid;
    assign m_read_byte     = flags_reg.read_valid ? rx_q : 8'd0;
    assign m_line_valid    = flags_reg.line_valid;
    assign m_line_byte     = flags_reg.line_valid ? tx_q : 8'd0;
    assign m_send_refused  = flags_reg.send_refused;
    assign m_rx_dropped    = flags_reg.rx_dropped;
    assign m_tx_irq_enable = flags_reg.tx_irq_enable;
    assign m_tx_space      = flags_reg.tx_space;
    assign m_tx_empty      = flags_reg.tx_empty;
    assign m_rx_empty      = flags_reg.rx_empty;

endmodule

@@ design/udrb_checker.sv @@
// Port-level checker for the dual ring buffer core, bound to the top level.
`timescale 1ns / 1ps
`include "uart_dual_ring_buffer_core_defines.svh"
module udrb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_byte,
    input logic       m_read_valid,
    input logic [7:0] m_line_byte,
    input logic       m_line_valid,
    input logic       m_send_refused,
    input logic       m_rx_dropped,
    input logic       m_tx_space,
    input logic       m_tx_empty,
    input logic       m_rx_empty
);

    logic        out_stall;
    logic [16:0] out_bus;
    logic        refused;
    logic        tx_full_seen;
    logic        read_done;
    logic        other_flags;
    logic        no_byte;
    logic        bytes_zero;

    assign out_stall    = m_valid && !m_ready;
    assign out_bus      = {m_read_byte, m_line_byte, m_tx_empty};
    assign refused      = m_valid && m_send_refused;
    assign tx_full_seen = !m_tx_space && !m_tx_empty;
    assign read_done    = m_valid && m_read_valid;
    assign other_flags  = m_line_valid || m_send_refused || m_rx_dropped;
    assign no_byte      = m_valid && !m_read_valid && !m_line_valid;
    assign bytes_zero   = ((m_read_byte | m_line_byte) == 8'd0);

    `UDRB_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(out_bus))
    `UDRB_ASSERT_IMPL(a_refused_full, aclk, aresetn, refused, tx_full_seen)
    `UDRB_ASSERT_IMPL(a_dropped_full, aclk, aresetn, m_valid && m_rx_dropped, !m_rx_empty)
    `UDRB_ASSERT_IMPL(a_one_kind, aclk, aresetn, read_done, !other_flags)
    `UDRB_ASSERT_IMPL(a_zero_bytes, aclk, aresetn, no_byte, bytes_zero)

endmodule

bind uart_dual_ring_buffer_core udrb_checker u_udrb_checker (.*);

@@ sim/uart_dual_ring_buffer_core_tb.sv @@
// Self-checking testbench for the dual ring buffer core: directed and random transactions.
`timescale 1ns / 1ps
module uart_dual_ring_buffer_core_tb;
    import udrb_pkg::*;

    localparam logic [2:0] KIND_RSVD_6 = 3'd6;
    localparam logic [2:0] KIND_RSVD_7 = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic [7:0] line_byte;
        logic       line_valid;
        logic       send_refused;
        logic       rx_dropped;
        logic       tx_irq_enable;
        logic       tx_space;
        logic       tx_empty;
        logic       rx_empty;
    } ring_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_kind = KIND_SEND;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_line_ready = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_byte;
    logic       m_read_valid;
    logic [7:0] m_line_byte;
    logic       m_line_valid;
    logic       m_send_refused;
    logic       m_rx_dropped;
    logic       m_tx_irq_enable;
    logic       m_tx_space;
    logic       m_tx_empty;
    logic       m_rx_empty;

    // shadow state of the rings
    logic             model_enabled = 1'b0;
    logic [7:0]       tx_ring [TX_DEPTH];
    logic [TX_AW-1:0] tx_wr_ptr = '0;
    logic [TX_AW-1:0] tx_rd_ptr = '0;
    logic [TX_CW-1:0] tx_level = '0;
    logic [7:0]       rx_ring [RX_DEPTH];
    logic [RX_AW-1:0] rx_wr_ptr = '0;
    logic [RX_AW-1:0] rx_rd_ptr = '0;
    logic [RX_CW-1:0] rx_level = '0;
    logic             tx_irq_on = 1'b0;

    ring_result_t expected_results [$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    int  hold_request = 0;
    int  hold_left = 0;

    uart_dual_ring_buffer_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_data_byte    (s_data_byte),
        .s_line_ready   (s_line_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_byte    (m_read_byte),
        .m_read_valid   (m_read_valid),
        .m_line_byte    (m_line_byte),
        .m_line_valid   (m_line_valid),
        .m_send_refused (m_send_refused),
        .m_rx_dropped   (m_rx_dropped),
        .m_tx_irq_enable(m_tx_irq_enable),
        .m_tx_space     (m_tx_space),
        .m_tx_empty     (m_tx_empty),
        .m_rx_empty     (m_rx_empty)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ring indices wrap naturally: both depths are powers of two
    function automatic ring_result_t predict_ring_step(logic [2:0] kind, logic [7:0] data,
                                                       logic lr);
        ring_result_t r;
        r = '0;
        if (model_enabled) begin
            case (kind)
                KIND_SEND: begin
                    if (tx_level < TX_DEPTH) begin
                        tx_ring[tx_wr_ptr] = data;
                        tx_wr_ptr = tx_wr_ptr + 1'b1;
                        tx_level = tx_level + 1'b1;
                        tx_irq_on = 1'b1;
                    end else begin
                        r.send_refused = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (rx_level != 0) begin
                        r.read_byte = rx_ring[rx_rd_ptr];
                        r.read_valid = 1'b1;
                        rx_rd_ptr = rx_rd_ptr + 1'b1;
                        rx_level = rx_level - 1'b1;
                    end
                end
                KIND_LINE_RX: begin
                    if (rx_level < RX_DEPTH) begin
                        rx_ring[rx_wr_ptr] = data;
                        rx_wr_ptr = rx_wr_ptr + 1'b1;
                        rx_level = rx_level + 1'b1;
                    end else begin
                        r.rx_dropped = 1'b1;
                    end
                end
                KIND_TX_READY: begin
                    if (tx_level == 0) begin
                        tx_irq_on = 1'b0;
                    end else if (lr) begin
                        r.line_byte = tx_ring[tx_rd_ptr];
                        r.line_valid = 1'b1;
                        tx_rd_ptr = tx_rd_ptr + 1'b1;
                        tx_level = tx_level - 1'b1;
                    end
                end
                KIND_FLUSH_TX: begin
                    tx_level = '0;
                    tx_wr_ptr = '0;
                    tx_rd_ptr = '0;
                end
                KIND_FLUSH_RX: begin
                    rx_level = '0;
                    rx_wr_ptr = '0;
                    rx_rd_ptr = '0;
                end
                default: begin
                end
            endcase
        end
        r.tx_irq_enable = tx_irq_on;
        r.tx_space = !model_enabled || (tx_level < TX_DEPTH);
        r.tx_empty = !model_enabled || (tx_level == 0);
        r.rx_empty = !model_enabled || (rx_level == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        ring_result_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("read_byte", exp_r.read_byte, m_read_byte);
                    check_field("read_valid", 8'(exp_r.read_valid), 8'(m_read_valid));
                    check_field("line_byte", exp_r.line_byte, m_line_byte);
                    check_field("line_valid", 8'(exp_r.line_valid), 8'(m_line_valid));
                    check_field("send_refused", 8'(exp_r.send_refused),
                                8'(m_send_refused));
                    check_field("rx_dropped", 8'(exp_r.rx_dropped), 8'(m_rx_dropped));
                    check_field("tx_irq_enable", 8'(exp_r.tx_irq_enable),
                                8'(m_tx_irq_enable));
                    check_field("tx_space", 8'(exp_r.tx_space), 8'(m_tx_space));
                    check_field("tx_empty", 8'(exp_r.tx_empty), 8'(m_tx_empty));
                    check_field("rx_empty", 8'(exp_r.rx_empty), 8'(m_rx_empty));
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_ring_step(s_kind, s_data_byte,
                                                             s_line_ready));
        end
    end

    // result side: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_idle_on) begin
            m_ready <= ($urandom_range(99) >= 22);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_event(input logic [2:0] kind, input logic [7:0] data,
                              input logic lr);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(99) < 11)
            gap = $urandom_range(4, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_data_byte <= data;
        s_line_ready <= lr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_driver_enabled(input logic en);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= en;
        @(posedge aclk);
        model_enabled = en;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_event(input int send_pct);
        int r;
        logic [7:0] d;
        r = $urandom_range(99);
        d = 8'($urandom_range(255));
        if (r < send_pct)
            send_event(KIND_SEND, d, 1'($urandom_range(1)));
        else if (r < 50)
            send_event(KIND_TX_READY, d, $urandom_range(99) < 75);
        else if (r < 72)
            send_event(KIND_LINE_RX, d, 1'($urandom_range(1)));
        else if (r < 90)
            send_event(KIND_READ, d, 1'($urandom_range(1)));
        else if (r < 93)
            send_event(KIND_FLUSH_TX, d, 1'($urandom_range(1)));
        else if (r < 96)
            send_event(KIND_FLUSH_RX, d, 1'($urandom_range(1)));
        else
            send_event($urandom_range(1) ? KIND_RSVD_6 : KIND_RSVD_7, d,
                       1'($urandom_range(1)));
    endtask

    task automatic test_disabled_after_reset();
        send_event(KIND_SEND, 8'hA5, 1'b1);
        send_event(KIND_READ, 8'h00, 1'b0);
        send_event(KIND_LINE_RX, 8'h5A, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_FLUSH_TX, 8'h00, 1'b0);
        send_event(KIND_FLUSH_RX, 8'h00, 1'b0);
        send_event(KIND_RSVD_6, 8'hFF, 1'b1);
    endtask

    task automatic test_basic_transfer();
        set_driver_enabled(1'b1);
        send_event(KIND_READ, 8'h00, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_SEND, 8'h00, 1'b0);
        send_event(KIND_SEND, 8'hFF, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_TX_READY, 8'hFF, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_LINE_RX, 8'hFF, 1'b0);
        send_event(KIND_LINE_RX, 8'h00, 1'b1);
        send_event(KIND_READ, 8'h00, 1'b0);
        send_event(KIND_READ, 8'hFF, 1'b1);
        send_event(KIND_READ, 8'h00, 1'b0);
        send_event(KIND_RSVD_7, 8'h81, 1'b0);
    endtask

    task automatic test_tx_full();
        repeat (TX_DEPTH + 2) send_event(KIND_SEND, 8'($urandom_range(255)), 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_SEND, 8'h7E, 1'b0);
        send_event(KIND_SEND, 8'h7F, 1'b0);
    endtask

    task automatic test_disabled_holds_state();
        send_event(KIND_LINE_RX, 8'h3C, 1'b0);
        set_driver_enabled(1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_READ, 8'h00, 1'b0);
        send_event(KIND_SEND, 8'h11, 1'b0);
        send_event(KIND_LINE_RX, 8'h22, 1'b0);
        send_event(KIND_FLUSH_TX, 8'h00, 1'b0);
        send_event(KIND_FLUSH_RX, 8'h00, 1'b0);
        set_driver_enabled(1'b1);
        send_event(KIND_READ, 8'h00, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_FLUSH_TX, 8'h00, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_FLUSH_RX, 8'h00, 1'b0);
    endtask

    task automatic test_rx_bulk();
        send_event(KIND_FLUSH_RX, 8'h00, 1'b0);
        repeat (300) send_event(KIND_LINE_RX, 8'($urandom_range(255)),
                                1'($urandom_range(1)));
        repeat (3) send_event(KIND_READ, 8'h00, 1'b0);
        repeat (4) send_event(KIND_LINE_RX, 8'($urandom_range(255)), 1'b0);
        repeat (3) send_event(KIND_READ, 8'h00, 1'b1);
        send_event(KIND_FLUSH_RX, 8'h00, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        hold_request = 300;
        repeat (30) send_random_event(40);
        wait_results_drained();
    endtask

    task automatic test_source_pause();
        repeat (20) send_random_event(30);
        wait_results_drained();
        repeat (20) send_random_event(30);
    endtask

    task automatic test_random_phases();
        set_driver_enabled(1'b1);
        repeat (300) send_random_event(40);
        set_driver_enabled(1'b1);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        repeat (250) send_random_event(25);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        set_driver_enabled(1'b0);
        repeat (120) send_random_event(30);
        set_driver_enabled(1'b1);
        repeat (300) send_random_event(15);
        repeat (250) send_random_event(28);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_after_reset();
        test_basic_transfer();
        test_tx_full();
        test_disabled_holds_state();
        test_rx_bulk();
        test_backpressure();
        test_source_pause();
        test_random_phases();
        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/udrb_pkg.sv
design/udrb_ram.sv
design/udrb_ctrl.sv
design/uart_dual_ring_buffer_core.sv
design/udrb_checker.sv
sim/uart_dual_ring_buffer_core_tb.sv
